FILE: design/assert_macros.svh
// assert_macros.svh
// concurrent assertion macros shared by the rtl; no dependencies
// define NO_ASSERTIONS to compile them out

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define AFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define AFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/afp_pkg.sv
// afp_pkg.sv
// payload types, frame layout and event codes for the attitude frame parser
// no dependencies

package afp_pkg;

	// sync pattern
	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	// frame layout, byte positions
	localparam int unsigned FRAME_LEN = 12;
	localparam int unsigned POS_W     = 4;
	localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
	localparam logic [POS_W-1:0] POS_SECOND   = 4'd1;
	localparam logic [POS_W-1:0] POS_SUM_START = 4'd2;
	localparam logic [POS_W-1:0] POS_YAW_LO   = 4'd5;
	localparam logic [POS_W-1:0] POS_ROLL_HI  = 4'd10;
	localparam logic [POS_W-1:0] POS_CHECK    = 4'd11;

	// captured attitude bytes, positions 5 to 10
	localparam int unsigned CAP_N = 6;
	localparam int unsigned CAP_W = 3;

	// event codes
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_GOOD = 2'd1;
	localparam logic [1:0] EV_BAD  = 2'd2;

	// line event kinds
	localparam logic MODE_BYTE  = 1'b0;
	localparam logic MODE_ERROR = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} afp_in_t;

	typedef struct packed {
		logic [1:0]         event_res;
		logic [15:0]        yaw_centideg;
		logic signed [15:0] pitch_centideg;
		logic signed [15:0] roll_centideg;
		logic [31:0]        good_frames;
		logic [31:0]        bad_sums;
		logic               have_attitude;
	} afp_out_t;

endpackage

FILE: design/attitude_frame_parser.sv
// attitude frame parser: one result per received byte or line-error event
// throughput: one transaction per cycle; input register, then frame logic and
// the result register; stalls only while both stages hold undelivered items
// reset: hunt position, attitude, counters and valid flags clear asynchronously
// depends on afp_pkg and assert_macros.svh

`include "assert_macros.svh"

module attitude_frame_parser
	import afp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  afp_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output afp_out_t result
);

	logic            valid_s1;
	afp_in_t         item_s1;
	logic            advance;
	logic            load_res;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       cap_q [CAP_N];
	logic [7:0]       cap_d [CAP_N];
	logic [15:0]      yaw_q, yaw_d;
	logic [15:0]      pitch_q, pitch_d;
	logic [15:0]      roll_q, roll_d;
	logic [31:0]      good_q, good_d;
	logic [31:0]      bad_q, bad_d;
	logic             have_q, have_d;
	logic [1:0]       ev_q, ev_d;
	logic             out_valid_q;
	logic [POS_W-1:0] cap_off;

	// handshake: result register frees when empty or taken
	assign advance    = !out_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign load_res   = valid_s1 && advance;
	assign cap_off    = pos_q - POS_YAW_LO;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// frame hunt, running sum and field capture
	always_comb begin
		pos_d   = pos_q;
		sum_d   = sum_q;
		cap_d   = cap_q;
		yaw_d   = yaw_q;
		pitch_d = pitch_q;
		roll_d  = roll_q;
		good_d  = good_q;
		bad_d   = bad_q;
		have_d  = have_q;
		ev_d    = EV_NONE;
		priority if (item_s1.mode == MODE_ERROR) begin
			pos_d = POS_HUNT;
		end else if (pos_q == POS_HUNT) begin
			if (item_s1.rx_byte == SYNC_FIRST) begin
				pos_d = POS_SECOND;
			end
		end else if (pos_q == POS_SECOND) begin
			priority if (item_s1.rx_byte == SYNC_SECOND) begin
				pos_d = POS_SUM_START;
			end else if (item_s1.rx_byte == SYNC_FIRST) begin
				pos_d = POS_SECOND;
			end else begin
				pos_d = POS_HUNT;
			end
		end else if (pos_q == POS_CHECK) begin
			pos_d = POS_HUNT;
			if (sum_q == item_s1.rx_byte) begin
				ev_d    = EV_GOOD;
				yaw_d   = {cap_q[1], cap_q[0]};
				pitch_d = {cap_q[3], cap_q[2]};
				roll_d  = {cap_q[5], cap_q[4]};
				good_d  = good_q + 32'd1;
				have_d  = 1'b1;
			end else begin
				ev_d  = EV_BAD;
				bad_d = bad_q + 32'd1;
			end
		end else if (pos_q < POS_CHECK) begin
			// payload bytes 2 to 10
			pos_d = pos_q + 4'd1;
			sum_d = (pos_q == POS_SUM_START) ? item_s1.rx_byte
				: sum_q + item_s1.rx_byte;
			if (pos_q >= POS_YAW_LO && pos_q <= POS_ROLL_HI) begin
				cap_d[cap_off[CAP_W-1:0]] = item_s1.rx_byte;
			end
		end else begin
			pos_d = POS_HUNT;
		end
	end

	// parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HUNT;
			yaw_q       <= '0;
			pitch_q     <= '0;
			roll_q      <= '0;
			good_q      <= '0;
			bad_q       <= '0;
			have_q      <= 1'b0;
			ev_q        <= EV_NONE;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				pos_q   <= pos_d;
				yaw_q   <= yaw_d;
				pitch_q <= pitch_d;
				roll_q  <= roll_d;
				good_q  <= good_d;
				bad_q   <= bad_d;
				have_q  <= have_d;
				ev_q    <= ev_d;
			end
		end
	end

	// frame bytes need no reset, every read byte is written first
	always_ff @(posedge clk) begin
		if (load_res) begin
			sum_q <= sum_d;
			cap_q <= cap_d;
		end
	end

	// result payload
	assign result_valid = out_valid_q;
	always_comb begin
		result.event_res      = ev_q;
		result.yaw_centideg   = yaw_q;
		result.pitch_centideg = pitch_q;
		result.roll_centideg  = roll_q;
		result.good_frames    = good_q;
		result.bad_sums       = bad_q;
		result.have_attitude  = have_q;
	end

	// checks
	`AFP_ASSERT_IMPLY(a_pos_range, clk, arst_n, 1'b1, pos_q <= POS_CHECK)
	`AFP_ASSERT_NEXT(a_good_count, clk, arst_n, load_res && ev_d == EV_GOOD, good_q == $past(good_q) + 32'd1 && have_q)
	`AFP_ASSERT_NEXT(a_have_sticky, clk, arst_n, have_q, have_q)
	`AFP_ASSERT_IMPLY(a_stall_full, clk, arst_n, !item_ready, valid_s1 && out_valid_q)

endmodule

FILE: tb/testbench.sv
// testbench.sv
// self-checking testbench for attitude_frame_parser: sync hunt, frame capture,
// checksum and line-error handling, all checked by a cycle-free predictor; needs afp_pkg
`timescale 1ns / 1ps

module testbench
	import afp_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOWN_MISMATCHES = 10;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     item_valid;
	logic     item_ready;
	afp_in_t  item;
	logic     result_valid;
	logic     result_ready;
	afp_out_t result;

	// predictor state
	logic [POS_W-1:0] frame_pos;
	logic [7:0]       frame_buf [FRAME_LEN];
	logic [15:0]      att_yaw;
	logic [15:0]      att_pitch;
	logic [15:0]      att_roll;
	logic [31:0]      good_total;
	logic [31:0]      bad_total;
	logic             attitude_seen;

	afp_out_t expected_reports [$];

	int send_idle_pct;
	int take_idle_pct;
	int items_sent;
	int line_errors;
	int mismatches;
	int cycles;

	attitude_frame_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped at cycle limit, %0d reports outstanding",
				expected_reports.size());
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= take_idle_pct);
	end

	// advance the parser state by one transaction and return the report it gives
	function automatic afp_out_t parse_byte(afp_in_t tr);
		afp_out_t   rep;
		logic [7:0] sum;
		rep.event_res = EV_NONE;
		if (tr.mode == MODE_ERROR) begin
			frame_pos = POS_HUNT;
		end else if (frame_pos == POS_HUNT) begin
			if (tr.rx_byte == SYNC_FIRST) begin
				frame_buf[0] = tr.rx_byte;
				frame_pos = POS_SECOND;
			end
		end else if (frame_pos == POS_SECOND) begin
			if (tr.rx_byte == SYNC_SECOND) begin
				frame_buf[1] = tr.rx_byte;
				frame_pos = POS_SUM_START;
			end else if (tr.rx_byte == SYNC_FIRST) begin
				frame_buf[0] = tr.rx_byte;
			end else begin
				frame_pos = POS_HUNT;
			end
		end else if (frame_pos < FRAME_LEN) begin
			frame_buf[frame_pos] = tr.rx_byte;
			if (frame_pos == POS_CHECK) begin
				// 8-bit sum over the data bytes against the trailing byte
				sum = 8'h00;
				for (int k = POS_SUM_START; k < POS_CHECK; k++)
					sum = sum + frame_buf[k];
				if (sum != frame_buf[POS_CHECK]) begin
					bad_total = bad_total + 32'd1;
					rep.event_res = EV_BAD;
				end else begin
					att_yaw   = {frame_buf[POS_YAW_LO + 1], frame_buf[POS_YAW_LO]};
					att_pitch = {frame_buf[POS_YAW_LO + 3], frame_buf[POS_YAW_LO + 2]};
					att_roll  = {frame_buf[POS_ROLL_HI], frame_buf[POS_ROLL_HI - 1]};
					good_total = good_total + 32'd1;
					attitude_seen = 1'b1;
					rep.event_res = EV_GOOD;
				end
				frame_pos = POS_HUNT;
			end else begin
				frame_pos = frame_pos + 4'd1;
			end
		end else begin
			frame_pos = POS_HUNT;
		end
		rep.yaw_centideg   = att_yaw;
		rep.pitch_centideg = att_pitch;
		rep.roll_centideg  = att_roll;
		rep.good_frames    = good_total;
		rep.bad_sums       = bad_total;
		rep.have_attitude  = attitude_seen;
		return rep;
	endfunction

	task automatic note_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES)
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
	endtask

	// predict on each input transaction, compare each result transaction
	always @(posedge clk) begin : scoreboard
		afp_out_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				if (item.mode == MODE_ERROR)
					line_errors++;
				expected_reports.push_back(parse_byte(item));
			end
			if (result_valid && result_ready) begin
				if (expected_reports.size() == 0) begin
					note_mismatch("unexpected report", 0, result.event_res);
				end else begin
					want = expected_reports.pop_front();
					if (result.event_res != want.event_res)
						note_mismatch("event", want.event_res, result.event_res);
					if (result.yaw_centideg != want.yaw_centideg)
						note_mismatch("yaw", want.yaw_centideg, result.yaw_centideg);
					if (result.pitch_centideg != want.pitch_centideg)
						note_mismatch("pitch", want.pitch_centideg, result.pitch_centideg);
					if (result.roll_centideg != want.roll_centideg)
						note_mismatch("roll", want.roll_centideg, result.roll_centideg);
					if (result.good_frames != want.good_frames)
						note_mismatch("good frames", want.good_frames, result.good_frames);
					if (result.bad_sums != want.bad_sums)
						note_mismatch("bad sums", want.bad_sums, result.bad_sums);
					if (result.have_attitude != want.have_attitude)
						note_mismatch("have attitude", want.have_attitude,
							result.have_attitude);
				end
			end
		end
	end

	// drive one transaction, with a random gap in front of it
	task automatic send_item(input logic mode, input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item <= '{mode: mode, rx_byte: b};
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	// hold off until every outstanding report has come back
	task automatic wait_until_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	// send a frame; a nonzero flip spoils the checksum, a cut below the frame
	// length ends it early with a line error
	task automatic send_frame(input logic [15:0] yaw, input logic [15:0] pitch,
			input logic [15:0] roll, input logic [23:0] lead, input logic [7:0] flip,
			input int cut_at);
		logic [7:0] body [FRAME_LEN];
		logic [7:0] sum;
		body[0] = SYNC_FIRST;
		body[1] = SYNC_SECOND;
		body[POS_SUM_START]     = lead[7:0];
		body[POS_SUM_START + 1] = lead[15:8];
		body[POS_SUM_START + 2] = lead[23:16];
		body[POS_YAW_LO]        = yaw[7:0];
		body[POS_YAW_LO + 1]    = yaw[15:8];
		body[POS_YAW_LO + 2]    = pitch[7:0];
		body[POS_YAW_LO + 3]    = pitch[15:8];
		body[POS_ROLL_HI - 1]   = roll[7:0];
		body[POS_ROLL_HI]       = roll[15:8];
		sum = 8'h00;
		for (int k = POS_SUM_START; k < POS_CHECK; k++)
			sum = sum + body[k];
		body[POS_CHECK] = sum ^ flip;
		for (int i = 0; i < cut_at && i < FRAME_LEN; i++)
			send_item(MODE_BYTE, body[i]);
		if (cut_at < FRAME_LEN)
			send_item(MODE_ERROR, 8'($urandom_range(255)));
	endtask

	// attitude word biased toward the range ends
	function automatic logic [15:0] pick_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// noise at hunt, other byte after first sync, line error
	task automatic test_sync_hunt();
		send_item(MODE_BYTE, SYNC_SECOND);
		send_item(MODE_BYTE, SYNC_FIRST);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, SYNC_FIRST);
		send_item(MODE_ERROR, 8'hFF);
	endtask

	// repeated first sync byte, then a good frame with extreme values
	task automatic test_extreme_frame();
		send_item(MODE_BYTE, SYNC_FIRST);
		send_frame(16'hFFFF, 16'h8000, 16'h7FFF, 24'hFF00FF, 8'h00, FRAME_LEN);
	endtask

	// spoiled checksum keeps the attitude
	task automatic test_checksum_mismatch();
		send_frame(16'h0000, 16'h7FFF, 16'h8000, 24'h00FF00, 8'h80, FRAME_LEN);
	endtask

	// mostly well-formed frames, mixed with spoiled, cut and noisy sequences
	task automatic test_random_traffic(input int n);
		int stop_at;
		int kind;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 60) begin
				send_frame(pick_word(), pick_word(), pick_word(), 24'($urandom), 8'h00,
					FRAME_LEN);
			end else if (kind < 72) begin
				send_frame(pick_word(), pick_word(), pick_word(), 24'($urandom),
					8'($urandom_range(1, 255)), FRAME_LEN);
			end else if (kind < 82) begin
				send_frame(pick_word(), pick_word(), pick_word(), 24'($urandom), 8'h00,
					$urandom_range(1, FRAME_LEN - 1));
			end else if (kind < 88) begin
				send_item(MODE_BYTE, SYNC_FIRST);
				send_frame(pick_word(), pick_word(), pick_word(), 24'($urandom), 8'h00,
					FRAME_LEN);
			end else if (kind < 94) begin
				send_item(MODE_BYTE, SYNC_FIRST);
				send_item(MODE_BYTE, 8'($urandom_range(255)));
			end else if (kind < 98) begin
				repeat ($urandom_range(1, 4))
					send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
			end else begin
				wait_until_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		send_idle_pct = 0;
		take_idle_pct = 0;
		frame_pos = POS_HUNT;
		foreach (frame_buf[i]) frame_buf[i] = 8'h00;
		att_yaw = '0;
		att_pitch = '0;
		att_roll = '0;
		good_total = '0;
		bad_total = '0;
		attitude_seen = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles rarely, receiver often
		send_idle_pct = 13;
		take_idle_pct = 62;
		test_sync_hunt();
		test_extreme_frame();
		test_checksum_mismatch();
		test_random_traffic(240);
		wait_until_drained();

		// sender idles often, receiver rarely
		send_idle_pct = 62;
		take_idle_pct = 13;
		test_random_traffic(240);
		wait_until_drained();

		// back to back
		send_idle_pct = 0;
		take_idle_pct = 0;
		test_random_traffic(240);

		wait_until_drained();
		repeat (4) @(posedge clk);
		$display("sent %0d transactions: %0d frames accepted, %0d checksum mismatches,",
			items_sent, good_total, bad_total);
		$display("%0d line errors, under three sender and receiver stall mixes",
			line_errors);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/afp_pkg.sv
design/attitude_frame_parser.sv
tb/testbench.sv
